// ===== sv/bce_pkg.sv =====
package bce_pkg;

    localparam int NUM_COEFS  = 5;
    localparam int COEF_W     = 32;
    localparam int HIST_EXTRA = 8;
    localparam int MASK_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int MIX_W      = 17;
    localparam int GAIN_FRAC  = 13;
    localparam int MIX_FRAC   = 16;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    localparam logic [MIX_W-1:0]  MIX_FULL   = 17'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

    localparam logic [1:0] REG_MASK = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_MIX  = 2'd2;

    typedef enum logic [1:0] {
        OP_PROC  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        C_B0 = 3'd0,
        C_B1 = 3'd1,
        C_B2 = 3'd2,
        C_A1 = 3'd3,
        C_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [1:0] {
        MUL_Y,
        MUL_F,
        MUL_GAIN,
        MUL_MIX
    } t_mul_src;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BAND,
        S_GAIN,
        S_MIX,
        S_OUT
    } t_state;

    typedef struct packed {
        logic      load;
        logic      coef_wr;
        logic      hist_clr;
        logic      coef_rd;
        t_coef_sel csel;
        logic      hist_rd;
        logic      mul_en;
        t_mul_src  msrc;
        logic      f_en;
        logic      acc1_ld;
        logic      acc1_sub;
        logic      acc2_ld;
        logic      acc2_sub;
        logic      hist_wr;
        logic      y_upd;
        logic      wet_en;
        logic      out_load;
    } t_cmd;

endpackage

// ===== sv/bce_ram.sv =====
module bce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/bce_ctrl.sv =====
module bce_ctrl #(
    parameter int NUM_BANDS    = 8,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [1:0]                             i_op,
    input  logic                                   i_channel,
    input  logic [bce_pkg::MASK_W-1:0]             i_mask,
    input  logic                                   i_out_busy,
    output logic                                   o_stall,
    output logic [$clog2(NUM_BANDS+1)-1:0]         o_band,
    output bce_pkg::t_cmd                          o_cmd
);
    import bce_pkg::*;

    localparam int BAND_W = $clog2(NUM_BANDS + 1);

    t_state            r_state, n_state;
    logic [2:0]        r_step, n_step;
    logic [BAND_W-1:0] r_band, n_band;
    logic              accept;
    logic              ch_ok;
    logic              bands_done;
    logic              bypass;
    logic [MASK_W-1:0] mask_sh;

    assign accept     = i_valid && (r_state == S_IDLE);
    assign ch_ok      = (32'(i_channel) < NUM_CHANNELS);
    assign bands_done = (r_band == BAND_W'(NUM_BANDS));
    assign mask_sh    = i_mask >> r_band;
    assign bypass     = mask_sh[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
            r_band  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_band  <= n_band;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_band  = r_band;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_op == OP_PROC) && ch_ok) begin
                    n_state = S_BAND;
                    n_step  = 3'd0;
                    n_band  = '0;
                end
            end
            S_BAND: begin
                if (bands_done) begin
                    n_state = S_GAIN;
                    n_step  = 3'd0;
                end else if ((r_step == 3'd0) && bypass) begin
                    n_band = r_band + 1'b1;
                end else if (r_step == 3'd7) begin
                    n_step = 3'd0;
                    n_band = r_band + 1'b1;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_GAIN: begin
                if (r_step == 3'd0) begin
                    n_step = 3'd1;
                end else begin
                    n_state = S_MIX;
                    n_step  = 3'd0;
                end
            end
            S_MIX: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.csel = C_B0;
        o_cmd.msrc = MUL_Y;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.coef_wr  = (i_op == OP_WRITE);
                    o_cmd.hist_clr = (i_op == OP_CLEAR);
                    o_cmd.load     = (i_op == OP_PROC) && ch_ok;
                end
            end
            S_BAND: begin
                if (!bands_done) begin
                    case (r_step)
                        3'd0: begin
                            o_cmd.coef_rd = !bypass;
                            o_cmd.hist_rd = !bypass;
                        end
                        3'd1: begin
                            o_cmd.coef_rd = 1'b1;
                            o_cmd.csel    = C_B1;
                            o_cmd.mul_en  = 1'b1;
                        end
                        3'd2: begin
                            o_cmd.coef_rd = 1'b1;
                            o_cmd.csel    = C_B2;
                            o_cmd.mul_en  = 1'b1;
                            o_cmd.f_en    = 1'b1;
                        end
                        3'd3: begin
                            o_cmd.coef_rd = 1'b1;
                            o_cmd.csel    = C_A1;
                            o_cmd.mul_en  = 1'b1;
                            o_cmd.acc1_ld = 1'b1;
                        end
                        3'd4: begin
                            o_cmd.coef_rd = 1'b1;
                            o_cmd.csel    = C_A2;
                            o_cmd.mul_en  = 1'b1;
                            o_cmd.msrc    = MUL_F;
                            o_cmd.acc2_ld = 1'b1;
                        end
                        3'd5: begin
                            o_cmd.mul_en   = 1'b1;
                            o_cmd.msrc     = MUL_F;
                            o_cmd.acc1_sub = 1'b1;
                        end
                        3'd6: begin
                            o_cmd.acc2_sub = 1'b1;
                        end
                        default: begin
                            o_cmd.hist_wr = 1'b1;
                            o_cmd.y_upd   = 1'b1;
                        end
                    endcase
                end
            end
            S_GAIN: begin
                if (r_step == 3'd0) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.msrc   = MUL_GAIN;
                end else begin
                    o_cmd.wet_en = 1'b1;
                end
            end
            S_MIX: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msrc   = MUL_MIX;
            end
            S_OUT: begin
                o_cmd.out_load = !i_out_busy;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_band  = r_band;
endmodule

// ===== sv/bce_dp.sv =====
module bce_dp #(
    parameter int NUM_BANDS      = 8,
    parameter int NUM_CHANNELS   = 2,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 27
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bce_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(NUM_BANDS+1)-1:0]         i_band,
    input  logic                                   i_channel,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic [2:0]                             i_band_index,
    input  logic [2:0]                             i_coef_select,
    input  logic signed [bce_pkg::COEF_W-1:0]      i_coef_value,
    input  logic [bce_pkg::GAIN_W-1:0]             i_gain,
    input  logic [bce_pkg::MIX_W-1:0]              i_mix,
    input  logic                                   i_out_stall,
    output logic                                   o_out_busy,
    output logic                                   o_valid,
    output logic                                   o_channel,
    output logic signed [SAMPLE_BITS-1:0]          o_sample
);
    import bce_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int HB    = SAMPLE_BITS + 16;
    localparam int PW    = COEF_W + SB + 1;
    localparam int ACC_W = PW + 2;
    localparam int CS    = COEF_FRAC_BITS - HIST_EXTRA;
    localparam int CD    = NUM_BANDS * NUM_COEFS;
    localparam int HD    = NUM_BANDS * NUM_CHANNELS;
    localparam int CAW   = (CD > 1) ? $clog2(CD) : 1;
    localparam int HAW   = (HD > 1) ? $clog2(HD) : 1;

    localparam logic signed [PW-1:0]    HALF_C  = PW'(1) <<< (CS - 1);
    localparam logic signed [PW-1:0]    HALF_G  = PW'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PW-1:0]    HALF_M  = PW'(1) <<< (MIX_FRAC - 1);
    localparam logic signed [ACC_W-1:0] HALF_F  = ACC_W'(1) <<< (HIST_EXTRA - 1);
    localparam logic signed [ACC_W-1:0] S_HI    = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] S_LO    = -S_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] H_HI    = (ACC_W'(1) <<< (HB - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] H_LO    = -H_HI - ACC_W'(1);
    localparam logic [COEF_W-1:0]       COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

    function automatic logic signed [SB-1:0] sat_s(input logic signed [ACC_W-1:0] v);
        logic signed [SB-1:0] r;
        if (v > S_HI) begin
            r = S_HI[SB-1:0];
        end else if (v < S_LO) begin
            r = S_LO[SB-1:0];
        end else begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [HB-1:0] sat_h(input logic signed [ACC_W-1:0] v);
        logic signed [HB-1:0] r;
        if (v > H_HI) begin
            r = H_HI[HB-1:0];
        end else if (v < H_LO) begin
            r = H_LO[HB-1:0];
        end else begin
            r = v[HB-1:0];
        end
        return r;
    endfunction

    logic [31:0]              caddr_full, cwaddr_full, haddr_full;
    logic [CAW-1:0]           caddr, cwaddr;
    logic [HAW-1:0]           haddr;
    logic                     cw_ok;
    logic [CD-1:0]            r_cvalid;
    logic [HD-1:0]            r_hvalid;
    logic                     r_cvld_rd, r_cb0_rd, r_hvld_rd;
    logic [COEF_W-1:0]        c_rdata;
    logic [HB-1:0]            h1_rdata, h2_rdata;
    logic signed [COEF_W-1:0] coef_q;
    logic signed [HB-1:0]     w1_q, w2_q;
    logic signed [HB-1:0]     h1_wdata, h2_wdata;

    logic signed [SB-1:0]     r_x, r_y, r_f;
    logic                     r_ch;
    logic signed [SB:0]       r_diff, diff_n;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [SB:0]       mul_b;
    logic signed [PW-1:0]     mul_p, r_prod;
    logic signed [PW-1:0]     p_rc, p_rg, p_rm;
    logic signed [ACC_W-1:0]  r_acc1, r_acc2, t_f;
    logic signed [SB-1:0]     f_n, wet_n, mixed_n;
    logic [MIX_W-1:0]         mix_c;

    logic                     r_valid;
    logic                     r_out_ch;
    logic signed [SB-1:0]     r_out;

    assign cwaddr_full = 32'(i_band_index) * NUM_COEFS + 32'(i_coef_select);
    assign cwaddr      = cwaddr_full[CAW-1:0];
    assign cw_ok       = (32'(i_band_index) < NUM_BANDS) && (32'(i_coef_select) < NUM_COEFS);
    assign caddr_full  = 32'(i_band) * NUM_COEFS + 32'(i_cmd.csel);
    assign caddr       = caddr_full[CAW-1:0];
    assign haddr_full  = 32'(i_band) * NUM_CHANNELS + 32'(r_ch);
    assign haddr       = haddr_full[HAW-1:0];

    bce_ram #(.WIDTH(COEF_W), .DEPTH(CD)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.coef_wr && cw_ok),
        .i_waddr (cwaddr),
        .i_wdata (i_coef_value),
        .i_re    (i_cmd.coef_rd),
        .i_raddr (caddr),
        .o_rdata (c_rdata)
    );

    bce_ram #(.WIDTH(HB), .DEPTH(HD)) u_hist1_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_wr),
        .i_waddr (haddr),
        .i_wdata (h1_wdata),
        .i_re    (i_cmd.hist_rd),
        .i_raddr (haddr),
        .o_rdata (h1_rdata)
    );

    bce_ram #(.WIDTH(HB), .DEPTH(HD)) u_hist2_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.hist_wr),
        .i_waddr (haddr),
        .i_wdata (h2_wdata),
        .i_re    (i_cmd.hist_rd),
        .i_raddr (haddr),
        .o_rdata (h2_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
            r_hvalid <= '0;
        end else begin
            if (i_cmd.coef_wr && cw_ok) begin
                r_cvalid[cwaddr] <= 1'b1;
            end
            if (i_cmd.hist_clr) begin
                r_hvalid <= '0;
            end else if (i_cmd.hist_wr) begin
                r_hvalid[haddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_rd) begin
            r_cvld_rd <= r_cvalid[caddr];
            r_cb0_rd  <= (i_cmd.csel == C_B0);
        end
        if (i_cmd.hist_rd) begin
            r_hvld_rd <= r_hvalid[haddr];
        end
    end

    assign coef_q   = r_cvld_rd ? c_rdata : (r_cb0_rd ? COEF_ONE : '0);
    assign w1_q     = r_hvld_rd ? h1_rdata : '0;
    assign w2_q     = r_hvld_rd ? h2_rdata : '0;
    assign h1_wdata = sat_h(r_acc1);
    assign h2_wdata = sat_h(r_acc2);

    assign mix_c = (i_mix > MIX_FULL) ? MIX_FULL : i_mix;

    always_comb begin
        case (i_cmd.msrc)
            MUL_Y: begin
                mul_a = coef_q;
                mul_b = (SB + 1)'(r_y);
            end
            MUL_F: begin
                mul_a = coef_q;
                mul_b = (SB + 1)'(r_f);
            end
            MUL_GAIN: begin
                mul_a = signed'(COEF_W'(i_gain));
                mul_b = (SB + 1)'(r_y);
            end
            default: begin
                mul_a = signed'(COEF_W'(mix_c));
                mul_b = r_diff;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign p_rc  = (r_prod + HALF_C) >>> CS;
    assign p_rg  = (r_prod + HALF_G) >>> GAIN_FRAC;
    assign p_rm  = (r_prod + HALF_M) >>> MIX_FRAC;

    assign t_f     = ACC_W'(p_rc) + ACC_W'(w1_q);
    assign f_n     = sat_s((t_f + HALF_F) >>> HIST_EXTRA);
    assign wet_n   = sat_s(ACC_W'(p_rg));
    assign diff_n  = wet_n - r_x;
    assign mixed_n = sat_s(ACC_W'(p_rm) + ACC_W'(r_x));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_sample;
            r_y  <= i_sample;
            r_ch <= i_channel;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.f_en) begin
            r_f <= f_n;
        end
        if (i_cmd.acc1_ld) begin
            r_acc1 <= ACC_W'(p_rc) + ACC_W'(w2_q);
        end else if (i_cmd.acc1_sub) begin
            r_acc1 <= r_acc1 - ACC_W'(p_rc);
        end
        if (i_cmd.acc2_ld) begin
            r_acc2 <= ACC_W'(p_rc);
        end else if (i_cmd.acc2_sub) begin
            r_acc2 <= r_acc2 - ACC_W'(p_rc);
        end
        if (i_cmd.y_upd) begin
            r_y <= r_f;
        end
        if (i_cmd.wet_en) begin
            r_diff <= diff_n;
        end
        if (i_cmd.out_load) begin
            r_out    <= mixed_n;
            r_out_ch <= r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_busy = r_valid && i_out_stall;
    assign o_valid    = r_valid;
    assign o_channel  = r_out_ch;
    assign o_sample   = r_out;
endmodule

// ===== sv/biquad_cascade_equalizer_top.sv =====
// Coefficient-write and clear beats leave the block idle and stall nothing.
// A sample beat runs each active band through the band sequence, skips bypassed bands,
// then applies the gain and the wet/dry mix and loads the output register.
// One shared 32 x 25 multiplier forms every product; one sample is in flight at a time, so
// a new sample beat is taken only after the previous result is in the output register.
// Reset is synchronous and active low; the coefficient store then reads as pass-through
// and the history as zero at once, with no clearing pass.
module biquad_cascade_equalizer_top #(
    parameter int NUM_BANDS      = 8,
    parameter int NUM_CHANNELS   = 2,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 27
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_op,
    input  logic                              i_channel,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample_in,
    input  logic [2:0]                        i_band_index,
    input  logic [2:0]                        i_coef_select,
    input  logic signed [31:0]                i_coef_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_channel_out,
    output logic signed [SAMPLE_BITS-1:0]     o_sample_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bce_pkg::APB_AW-1:0]        paddr,
    input  logic [bce_pkg::APB_DW-1:0]        pwdata,
    output logic [bce_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import bce_pkg::*;

    localparam int BAND_W = $clog2(NUM_BANDS + 1);

    logic [MASK_W-1:0] r_mask;
    logic [GAIN_W-1:0] r_gain;
    logic [MIX_W-1:0]  r_mix;
    logic              cfg_wr;
    logic [1:0]        reg_idx;
    logic              out_busy;
    logic [BAND_W-1:0] band;
    t_cmd              cmd;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_gain <= GAIN_RESET;
            r_mix  <= MIX_FULL;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MASK: r_mask <= pwdata[MASK_W-1:0];
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                REG_MIX:  r_mix  <= pwdata[MIX_W-1:0];
                default:  r_mask <= r_mask;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MASK: prdata = APB_DW'(r_mask);
            REG_GAIN: prdata = APB_DW'(r_gain);
            REG_MIX:  prdata = APB_DW'(r_mix);
            default:  prdata = '0;
        endcase
    end

    bce_ctrl #(
        .NUM_BANDS    (NUM_BANDS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_channel  (i_channel),
        .i_mask     (r_mask),
        .i_out_busy (out_busy),
        .o_stall    (o_stall),
        .o_band     (band),
        .o_cmd      (cmd)
    );

    bce_dp #(
        .NUM_BANDS      (NUM_BANDS),
        .NUM_CHANNELS   (NUM_CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_band        (band),
        .i_channel     (i_channel),
        .i_sample      (i_sample_in),
        .i_band_index  (i_band_index),
        .i_coef_select (i_coef_select),
        .i_coef_value  (i_coef_value),
        .i_gain        (r_gain),
        .i_mix         (r_mix),
        .i_out_stall   (i_stall),
        .o_out_busy    (out_busy),
        .o_valid       (o_valid),
        .o_channel     (o_channel_out),
        .o_sample      (o_sample_out)
    );

`ifndef SYNTHESIS
    a_proc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_op == OP_PROC) && (32'(i_channel) < NUM_CHANNELS))
        |=> o_stall)
        else $error("sample beat did not start the band sequence");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && ((i_op == OP_WRITE) || (i_op == OP_CLEAR))) |=> !o_stall)
        else $error("coefficient write or clear beat left the block busy");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result beat appeared without a sample in progress");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_valid && i_stall))
        else $error("output register overwritten while stalled");
`endif
endmodule
